// ===== hw/rtl/acdp_pkg.sv =====
// ----------------------------------------------------------------------------
// acdp_pkg
// Shared types and codes for the add/copy delta patch applier.
// ----------------------------------------------------------------------------
package acdp_pkg;

    localparam int OLD_ADDR_BITS_DEF = 16;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PATCH = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] PH_HLEN  = 3'd0;
    localparam logic [2:0] PH_HMODE = 3'd1;
    localparam logic [2:0] PH_OPLEN = 3'd2;
    localparam logic [2:0] PH_OPOFF = 3'd3;
    localparam logic [2:0] PH_ADD   = 3'd4;
    localparam logic [2:0] PH_COPY  = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;
    localparam logic [2:0] PH_STOP  = 3'd7;

    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_ADD_OVER  = 3'd1;
    localparam logic [2:0] ST_COPY_OVER = 3'd2;
    localparam logic [2:0] ST_SRC_RANGE = 3'd3;
    localparam logic [2:0] ST_REFUSED   = 3'd4;

    typedef struct packed {
        logic        rd;
        logic        lit;
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic [31:0] position;
        logic        last;
    } job_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic [31:0] position;
        logic        last;
    } res_t;

endpackage

// ===== hw/rtl/acdp_front.sv =====
// ----------------------------------------------------------------------------
// acdp_front
// Parses the patch stream and tracks loads; emits one job per result.
// ----------------------------------------------------------------------------
module acdp_front #(
    parameter int OLD_ADDR_BITS = acdp_pkg::OLD_ADDR_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [1:0]               command,
    input  logic [7:0]               byte_value,
    output logic                     wr_en,
    output logic [OLD_ADDR_BITS-1:0] wr_addr,
    output logic                     job_valid,
    output acdp_pkg::job_t           job,
    output logic [OLD_ADDR_BITS-1:0] rd_addr
);
    import acdp_pkg::*;

    localparam logic [OLD_ADDR_BITS:0] DEPTH = {1'b1, {OLD_ADDR_BITS{1'b0}}};

    logic [OLD_ADDR_BITS:0] old_count_reg, old_count_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] field_reg, field_next;
    logic [1:0]  fbytes_reg, fbytes_next;
    logic [31:0] target_reg, target_next;
    logic        narrow_reg, narrow_next;
    logic [31:0] wpos_reg, wpos_next;
    logic [31:0] run_reg, run_next;
    logic [31:0] src_reg, src_next;

    logic [31:0] acc;
    logic        full_field;
    logic        neg;
    logic [31:0] mag;
    logic [32:0] end_pos;
    logic [32:0] src_end;
    logic        emit_data;
    logic [7:0]  emit_byte;

    always_comb
    begin
        acc = field_reg | ({24'd0, byte_value} << {fbytes_reg, 3'b000});
        full_field = (phase_reg == PH_HLEN || !narrow_reg) ? (fbytes_reg == 2'd3)
                                                            : (fbytes_reg == 2'd1);
        neg = narrow_reg ? acc[15] : acc[31];
        mag = neg ? (narrow_reg ? ({16'd0, ~acc[15:0]} + 32'd1) : (~acc + 32'd1)) : acc;
        end_pos = {1'b0, wpos_reg} + {1'b0, (phase_reg == PH_OPLEN) ? mag : run_reg};
        src_end = {1'b0, acc} + {1'b0, run_reg};

        old_count_next = old_count_reg;
        phase_next = phase_reg;
        field_next = field_reg;
        fbytes_next = fbytes_reg;
        target_next = target_reg;
        narrow_next = narrow_reg;
        wpos_next = wpos_reg;
        run_next = run_reg;
        src_next = src_reg;
        wr_en = 1'b0;
        job_valid = 1'b0;
        job = '0;
        emit_data = 1'b0;
        emit_byte = byte_value;

        if (take)
        begin
            if (command == CMD_LOAD)
            begin
                if (old_count_reg < DEPTH)
                begin
                    wr_en = 1'b1;
                    old_count_next = old_count_reg + 1'b1;
                end
            end
            else if (command == CMD_TICK)
            begin
                if (phase_reg == PH_COPY)
                begin
                    emit_data = 1'b1;
                    src_next = src_reg + 32'd1;
                end
            end
            else if (command == CMD_PATCH)
            begin
                unique case (phase_reg)
                    PH_HLEN, PH_OPLEN, PH_OPOFF:
                    begin
                        field_next = acc;
                        fbytes_next = fbytes_reg + 2'd1;
                        if (full_field)
                        begin
                            field_next = '0;
                            fbytes_next = '0;
                            if (phase_reg == PH_HLEN)
                            begin
                                target_next = acc;
                                phase_next = PH_HMODE;
                            end
                            else if (phase_reg == PH_OPLEN)
                            begin
                                run_next = mag;
                                if (!neg)
                                    phase_next = PH_OPOFF;
                                else if (end_pos > {1'b0, target_reg})
                                begin
                                    phase_next = PH_STOP;
                                    job_valid = 1'b1;
                                    job.status = ST_ADD_OVER;
                                    job.position = wpos_reg;
                                end
                                else
                                    phase_next = PH_ADD;
                            end
                            else
                            begin
                                if (end_pos > {1'b0, target_reg})
                                begin
                                    phase_next = PH_STOP;
                                    job_valid = 1'b1;
                                    job.status = ST_COPY_OVER;
                                    job.position = wpos_reg;
                                end
                                else if (src_end > {{(32 - OLD_ADDR_BITS){1'b0}},
                                                    old_count_reg})
                                begin
                                    phase_next = PH_STOP;
                                    job_valid = 1'b1;
                                    job.status = ST_SRC_RANGE;
                                    job.position = wpos_reg;
                                end
                                else
                                begin
                                    src_next = acc;
                                    if (run_reg == 32'd0)
                                        phase_next = (wpos_reg >= target_reg) ? PH_DONE
                                                                              : PH_OPLEN;
                                    else
                                        phase_next = PH_COPY;
                                end
                            end
                        end
                    end
                    PH_HMODE:
                    begin
                        narrow_next = (byte_value != 8'd0);
                        phase_next = (wpos_reg >= target_reg) ? PH_DONE : PH_OPLEN;
                    end
                    PH_ADD:
                    begin
                        emit_data = 1'b1;
                        job.lit = 1'b1;
                    end
                    PH_COPY:
                    begin
                        job_valid = 1'b1;
                        job.status = ST_REFUSED;
                        job.position = wpos_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (emit_data)
            begin
                job_valid = 1'b1;
                job.rd = !job.lit;
                job.status = ST_DATA;
                job.data_byte = emit_byte;
                job.position = wpos_reg;
                job.last = (wpos_reg + 32'd1 == target_reg);
                wpos_next = wpos_reg + 32'd1;
                run_next = run_reg - 32'd1;
                if (run_reg == 32'd1)
                    phase_next = (wpos_reg + 32'd1 >= target_reg) ? PH_DONE : PH_OPLEN;
            end
        end
    end

    assign wr_addr = old_count_reg[OLD_ADDR_BITS-1:0];
    assign rd_addr = src_reg[OLD_ADDR_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_count_reg <= '0;
            phase_reg <= PH_HLEN;
            field_reg <= '0;
            fbytes_reg <= '0;
            target_reg <= '0;
            narrow_reg <= 1'b0;
            wpos_reg <= '0;
            run_reg <= '0;
            src_reg <= '0;
        end
        else
        begin
            old_count_reg <= old_count_next;
            phase_reg <= phase_next;
            field_reg <= field_next;
            fbytes_reg <= fbytes_next;
            target_reg <= target_next;
            narrow_reg <= narrow_next;
            wpos_reg <= wpos_next;
            run_reg <= run_next;
            src_reg <= src_next;
        end
    end

endmodule

// ===== hw/rtl/acdp_back.sv =====
// ----------------------------------------------------------------------------
// acdp_back
// Holds the old buffer, reads copy bytes and queues finished results.
// ----------------------------------------------------------------------------
module acdp_back #(
    parameter int OLD_ADDR_BITS = acdp_pkg::OLD_ADDR_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [OLD_ADDR_BITS-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     job_valid,
    input  acdp_pkg::job_t           job,
    input  logic [OLD_ADDR_BITS-1:0] rd_addr,
    input  logic                     pop,
    output logic                     full,
    output logic                     empty,
    output acdp_pkg::res_t           res
);
    import acdp_pkg::*;

    logic [7:0] mem [0:(1 << OLD_ADDR_BITS)-1];
    logic [7:0] rd_data_reg;
    logic       s1_valid_reg;
    job_t       s1_job_reg;
    res_t       q_reg [0:3];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    res_t       s1_res;
    logic       push_q, pop_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
        s1_job_reg <= job;
    end

    always_comb
    begin
        s1_res.status = s1_job_reg.status;
        s1_res.data_byte = s1_job_reg.rd ? rd_data_reg : s1_job_reg.data_byte;
        s1_res.position = s1_job_reg.position;
        s1_res.last = s1_job_reg.last;
    end

    assign push_q = s1_valid_reg;
    assign empty = (cnt_reg == 3'd0);
    assign pop_q = pop && !empty;
    assign full = (cnt_reg >= 3'd3);
    assign res = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push_q)
            q_reg[wp_reg] <= s1_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= job_valid;
            if (push_q)
                wp_reg <= wp_reg + 2'd1;
            if (pop_q)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push_q} - {2'd0, pop_q};
        end
    end

endmodule

// ===== hw/rtl/add_copy_delta_patch_applier.sv =====
// ----------------------------------------------------------------------------
// add_copy_delta_patch_applier
// Rebuilds a new buffer from a loaded old buffer and an add/copy patch stream.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake     Beat
// input    in         push / full   command, byte_value
// result   out        pop / empty   status, data_byte, position, last
//
// One beat is taken per cycle while full is low; each result is registered
// with the old-buffer read, then queued. Reset clears all control state; the
// old buffer is undefined until loaded. full rises when the result queue
// cannot absorb the beats still in flight, so each side stalls on its own.
module add_copy_delta_patch_applier #(
    parameter int OLD_ADDR_BITS = acdp_pkg::OLD_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  byte_value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [7:0]  data_byte,
    output logic [31:0] position,
    output logic        last
);
    import acdp_pkg::*;

    logic                     take;
    logic                     wr_en;
    logic [OLD_ADDR_BITS-1:0] wr_addr;
    logic [OLD_ADDR_BITS-1:0] rd_addr;
    logic                     job_valid;
    job_t                     job;
    res_t                     res;

    assign take = push && !full;

    acdp_front #(.OLD_ADDR_BITS(OLD_ADDR_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .command(command),
        .byte_value(byte_value), .wr_en(wr_en), .wr_addr(wr_addr),
        .job_valid(job_valid), .job(job), .rd_addr(rd_addr)
    );

    acdp_back #(.OLD_ADDR_BITS(OLD_ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(byte_value), .job_valid(job_valid), .job(job),
        .rd_addr(rd_addr), .pop(pop), .full(full), .empty(empty), .res(res)
    );

    assign status = res.status;
    assign data_byte = res.data_byte;
    assign position = res.position;
    assign last = res.last;

    a_no_job_without_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> take)
        else $error("result produced without an accepted beat");

    a_error_has_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_DATA) |-> !last)
        else $error("error result flagged as last");

    a_no_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && command == CMD_LOAD) |-> !job_valid)
        else $error("load beat produced a result");

endmodule

// ===== sim/add_copy_delta_patch_applier_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// add_copy_delta_patch_applier_tb
// Self-checking bench for the add/copy delta patch applier. A directed
// patch exercises loads, header, add and copy ops, ignored and refused beats;
// a random patch with random idling on both sides follows and ends in either
// a full new buffer or one of the overrun or source-range errors.
// ----------------------------------------------------------------------------
module add_copy_delta_patch_applier_tb;
    import acdp_pkg::*;

    localparam int          OLD_DEPTH  = 1 << OLD_ADDR_BITS_DEF;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          NEW_LENGTH = 1000;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] val;
        bit         typed;
        res_t       res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  command;
    logic [7:0]  byte_value;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [31:0] position;
    logic        last;

    // Predictor state.
    logic [7:0]  old_mem [OLD_DEPTH];
    logic [31:0] loaded;
    logic [2:0]  ph;
    logic [31:0] acc;
    int          acc_bytes;
    logic [31:0] new_len;
    bit          narrow;
    logic [31:0] wpos;
    logic [31:0] remaining;
    logic [31:0] src;

    res_t        pending_bytes[$];
    row_t        script[$];
    int          mismatches;
    int          pop_wait;
    bit          calm;

    add_copy_delta_patch_applier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .byte_value (byte_value),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .data_byte  (data_byte),
        .position   (position),
        .last       (last)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic bit gather_byte(input logic [7:0] b, input int n);
        acc = acc | (32'(b) << (8 * (acc_bytes & 3)));
        acc_bytes++;
        if (acc_bytes >= n)
        begin
            acc_bytes = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void after_op();
        ph = (wpos >= new_len) ? PH_DONE : PH_OPLEN;
    endfunction

    function automatic res_t new_byte(input logic [7:0] b);
        res_t r;
        r.status    = ST_DATA;
        r.data_byte = b;
        r.position  = wpos;
        wpos++;
        remaining--;
        r.last = (wpos == new_len);
        if (remaining == 0)
            after_op();
        return r;
    endfunction

    function automatic res_t fault(input logic [2:0] code);
        res_t r;
        r.status    = code;
        r.data_byte = 8'd0;
        r.position  = wpos;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic bit apply_beat(input logic [1:0] cmd, input logic [7:0] b,
                                      output res_t r);
        int          fw;
        logic [31:0] v;
        logic [31:0] mag;
        bit          neg;
        fw = narrow ? 2 : 4;
        r  = '0;
        if (cmd == CMD_LOAD)
        begin
            if (loaded < OLD_DEPTH)
            begin
                old_mem[loaded] = b;
                loaded++;
            end
            return 1'b0;
        end
        if (cmd == CMD_TICK)
        begin
            if (ph != PH_COPY)
                return 1'b0;
            r = new_byte(old_mem[src[OLD_ADDR_BITS_DEF-1:0]]);
            src++;
            return 1'b1;
        end
        if (cmd != CMD_PATCH)
            return 1'b0;
        case (ph)
            PH_HLEN:
            begin
                if (gather_byte(b, 4))
                begin
                    new_len = acc;
                    acc     = 0;
                    ph      = PH_HMODE;
                end
            end
            PH_HMODE:
            begin
                narrow = (b != 0);
                after_op();
            end
            PH_OPLEN:
            begin
                if (gather_byte(b, fw))
                begin
                    v   = acc;
                    acc = 0;
                    neg = narrow ? v[15] : v[31];
                    mag = neg ? (narrow ? 32'h10000 - v : 32'd0 - v) : v;
                    remaining = mag;
                    if (neg)
                    begin
                        if (33'(wpos) + 33'(mag) > 33'(new_len))
                        begin
                            ph = PH_STOP;
                            r  = fault(ST_ADD_OVER);
                            return 1'b1;
                        end
                        ph = PH_ADD;
                    end
                    else
                        ph = PH_OPOFF;
                end
            end
            PH_OPOFF:
            begin
                if (gather_byte(b, fw))
                begin
                    v   = acc;
                    acc = 0;
                    if (33'(wpos) + 33'(remaining) > 33'(new_len))
                    begin
                        ph = PH_STOP;
                        r  = fault(ST_COPY_OVER);
                        return 1'b1;
                    end
                    if (33'(v) + 33'(remaining) > 33'(loaded))
                    begin
                        ph = PH_STOP;
                        r  = fault(ST_SRC_RANGE);
                        return 1'b1;
                    end
                    src = v;
                    if (remaining == 0)
                        after_op();
                    else
                        ph = PH_COPY;
                end
            end
            PH_ADD:
            begin
                r = new_byte(b);
                return 1'b1;
            end
            PH_COPY:
            begin
                r = fault(ST_REFUSED);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b,
                             input bit typed, input res_t typed_res);
        int   gap;
        res_t r;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        command    <= cmd;
        byte_value <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (apply_beat(cmd, b, r))
            pending_bytes.push_back(typed ? typed_res : r);
    endtask

    task automatic send_field(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            send_beat(CMD_PATCH, v[8*i +: 8], 1'b0, '0);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_beat(CMD_LOAD, 8'($urandom), 1'b0, '0);
            1: send_beat(CMD_UNUSED, 8'($urandom), 1'b0, '0);
            default: send_beat(CMD_TICK, 8'($urandom), 1'b0, '0);
        endcase
    endtask

    function automatic void add_row(input logic [1:0] cmd, input logic [7:0] b);
        script.push_back('{cmd, b, 1'b0, '0});
    endfunction

    function automatic void add_typed(input logic [1:0] cmd, input logic [7:0] b,
                                      input logic [2:0] st, input logic [7:0] d,
                                      input logic [31:0] pos);
        res_t r;
        r = '{st, d, pos, 1'b0};
        script.push_back('{cmd, b, 1'b1, r});
    endfunction

    function automatic void add_field(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            add_row(CMD_PATCH, v[8*i +: 8]);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: status %0d data %02h pos %0d last %0b",
                                 status, data_byte, position, last);
                end
                else
                begin
                    res_t e;
                    e = pending_bytes.pop_front();
                    if (e.status !== status || e.data_byte !== data_byte ||
                        e.position !== position || e.last !== last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
                                     e.status, e.data_byte, e.position, e.last,
                                     status, data_byte, position, last);
                    end
                end
                pop_wait = calm ? 0 : $urandom_range(0, 12);
            end
            else if (pop_wait > 0)
                pop_wait--;
            pop <= (pop_wait == 0);
        end
    end

    initial
    begin
        int          fw;
        int          len;
        int          ending;
        int          items;
        logic [31:0] off;

        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        command    = CMD_LOAD;
        byte_value = 8'd0;
        mismatches = 0;
        pop_wait   = 0;
        calm       = 1'b0;
        loaded     = 0;
        ph         = PH_HLEN;
        acc        = 0;
        acc_bytes  = 0;
        new_len    = 0;
        narrow     = 1'b0;
        wpos       = 0;
        remaining  = 0;
        src        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        narrow = $urandom_range(0, 1);
        fw     = narrow ? 2 : 4;
        add_row(CMD_LOAD, 8'h00);
        add_row(CMD_LOAD, 8'hFF);
        add_row(CMD_LOAD, 8'h01);
        add_row(CMD_LOAD, 8'h80);
        add_row(CMD_LOAD, 8'h7F);
        add_row(CMD_LOAD, 8'hAA);
        add_row(CMD_LOAD, 8'h55);
        add_row(CMD_LOAD, 8'h3C);
        add_row(CMD_TICK, 8'h00);
        add_row(CMD_UNUSED, 8'hFF);
        add_field(NEW_LENGTH, 4);
        add_row(CMD_PATCH, narrow ? 8'hFF : 8'h00);
        add_field(-32'sd2, fw);
        add_typed(CMD_PATCH, 8'hFF, ST_DATA, 8'hFF, 0);
        add_row(CMD_LOAD, 8'h5A);
        add_typed(CMD_PATCH, 8'h00, ST_DATA, 8'h00, 1);
        add_field(0, fw);
        add_field(7, fw);
        add_field(3, fw);
        add_field(0, fw);
        add_typed(CMD_TICK, 8'h00, ST_DATA, 8'h00, 2);
        add_typed(CMD_TICK, 8'hFF, ST_DATA, 8'hFF, 3);
        add_typed(CMD_PATCH, 8'h12, ST_REFUSED, 8'h00, 4);
        add_typed(CMD_TICK, 8'h00, ST_DATA, 8'h01, 4);
        // The mode byte decides the field width, so the predictor resets it.
        narrow = 1'b0;
        foreach (script[i])
            send_beat(script[i].cmd, script[i].val, script[i].typed, script[i].res);

        items = 0;
        while (items < 1500 && wpos + 40 < new_len)
        begin
            if (items % 200 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (items > 700 && items < 720 && pending_bytes.size() != 0)
            begin
                push <= 1'b0;
                while (pending_bytes.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_noise();
                items++;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                len = $urandom_range(1, 8);
                send_field(-len, fw);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_noise();
                    send_beat(CMD_PATCH, 8'($urandom), 1'b0, '0);
                end
                items += fw + len;
            end
            else
            begin
                len = $urandom_range(0, 8);
                off = $urandom_range(0, loaded - len);
                send_field(len, fw);
                send_field(off, fw);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        send_beat(CMD_PATCH, 8'($urandom), 1'b0, '0);
                    if ($urandom_range(0, 15) == 0)
                        send_beat(CMD_LOAD, 8'($urandom), 1'b0, '0);
                    send_beat(CMD_TICK, 8'($urandom), 1'b0, '0);
                end
                items += 2 * fw + len;
            end
        end

        calm   = 1'b0;
        ending = $urandom_range(0, 3);
        case (ending)
            0:
            begin
                len = new_len - wpos;
                send_field(-len, fw);
                for (int i = 0; i < len; i++)
                    send_beat(CMD_PATCH, 8'($urandom), 1'b0, '0);
            end
            1:
                send_field(narrow ? 32'h8000 : 32'h8000_0000, fw);
            2:
            begin
                send_field(narrow ? 32'h7FFF : 32'h7FFF_FFFF, fw);
                send_field(0, fw);
            end
            default:
            begin
                calm = 1'b1;
                while (loaded < OLD_DEPTH)
                    send_beat(CMD_LOAD, 8'($urandom), 1'b0, '0);
                repeat (4) send_beat(CMD_LOAD, 8'($urandom), 1'b0, '0);
                calm = 1'b0;
                send_field(2, fw);
                send_field(OLD_DEPTH - 1, fw);
            end
        endcase
        repeat (6)
        begin
            send_beat(CMD_PATCH, 8'($urandom), 1'b0, '0);
            send_beat(CMD_TICK, 8'($urandom), 1'b0, '0);
        end
        push <= 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
